/* design/pdcr_pkg.sv */
// shared types, constants and microcode table of the phase decoder
package pdcr_pkg;

    // decoder configuration
    localparam logic [2:0] SYNC_BITS   = 3'd7;
    localparam logic [2:0] DELAY_DEPTH = 3'd3;
    localparam logic [2:0] QUEUE_FULL  = DELAY_DEPTH + 3'd1;

    localparam int ACC_W    = 24;
    localparam int PROD_W   = 33;
    localparam int DIV_W    = 28;
    localparam int UPC_W    = 5;

    localparam logic [7:0] TOL_RESET = 8'd38;

    // micro-operations
    localparam logic [3:0] UOP_NOP      = 4'd0;
    localparam logic [3:0] UOP_LOAD     = 4'd1;
    localparam logic [3:0] UOP_ACCUM    = 4'd2;
    localparam logic [3:0] UOP_MUL_LO   = 4'd3;
    localparam logic [3:0] UOP_MUL_HI   = 4'd4;
    localparam logic [3:0] UOP_COMPARE  = 4'd5;
    localparam logic [3:0] UOP_DECIDE   = 4'd6;
    localparam logic [3:0] UOP_MUL_AVG  = 4'd7;
    localparam logic [3:0] UOP_SUM_AVG  = 4'd8;
    localparam logic [3:0] UOP_DIV_STEP = 4'd9;
    localparam logic [3:0] UOP_AVG_DONE = 4'd10;
    localparam logic [3:0] UOP_EMIT     = 4'd11;

    // wait selects
    localparam logic [1:0] WAIT_NONE   = 2'd0;
    localparam logic [1:0] WAIT_INPUT  = 2'd1;
    localparam logic [1:0] WAIT_OUTPUT = 2'd2;

    // jump selects
    localparam logic [1:0] JMP_NEVER  = 2'd0;
    localparam logic [1:0] JMP_ALWAYS = 2'd1;
    localparam logic [1:0] JMP_ACTION = 2'd2;
    localparam logic [1:0] JMP_NO_AVG = 2'd3;

    // program addresses
    localparam logic [UPC_W-1:0] ADDR_IDLE      = 5'd0;
    localparam logic [UPC_W-1:0] ADDR_ACCUM     = 5'd1;
    localparam logic [UPC_W-1:0] ADDR_MUL_LO    = 5'd2;
    localparam logic [UPC_W-1:0] ADDR_MUL_HI    = 5'd3;
    localparam logic [UPC_W-1:0] ADDR_COMPARE   = 5'd4;
    localparam logic [UPC_W-1:0] ADDR_DECIDE    = 5'd5;
    localparam logic [UPC_W-1:0] ADDR_MUL_AVG   = 5'd6;
    localparam logic [UPC_W-1:0] ADDR_SUM_AVG   = 5'd7;
    localparam logic [UPC_W-1:0] ADDR_DIV_FIRST = 5'd8;
    localparam logic [UPC_W-1:0] ADDR_DIV_LAST  = 5'd14;
    localparam logic [UPC_W-1:0] ADDR_AVG_DONE  = 5'd15;
    localparam logic [UPC_W-1:0] ADDR_EMIT      = 5'd16;

    typedef struct packed {
        logic        action;
        logic        level;
        logic [15:0] elapsed;
    } pdcr_in_t;

    typedef struct packed {
        logic bit_valid;
        logic data_bit;
        logic clock_line;
    } pdcr_out_t;

    typedef struct packed {
        logic [3:0]       uop;
        logic [1:0]       wait_sel;
        logic [1:0]       jmp_sel;
        logic [UPC_W-1:0] target;
    } pdcr_uword_t;

    // sequencer to datapath
    typedef struct packed {
        logic       idle;
        logic [3:0] uop;
    } pdcr_ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic action;
        logic avg_needed;
    } pdcr_flags_t;

    function automatic pdcr_uword_t uword(input logic [3:0] uop, input logic [1:0] wait_sel,
                                          input logic [1:0] jmp_sel,
                                          input logic [UPC_W-1:0] target);
        pdcr_uword_t w;
        w.uop      = uop;
        w.wait_sel = wait_sel;
        w.jmp_sel  = jmp_sel;
        w.target   = target;
        return w;
    endfunction

    // control store
    function automatic pdcr_uword_t ucode_rom(input logic [UPC_W-1:0] addr);
        pdcr_uword_t w;
        unique case (addr) inside
            ADDR_IDLE:      w = uword(UOP_LOAD, WAIT_INPUT, JMP_NEVER, ADDR_IDLE);
            ADDR_ACCUM:     w = uword(UOP_ACCUM, WAIT_NONE, JMP_ACTION, ADDR_EMIT);
            ADDR_MUL_LO:    w = uword(UOP_MUL_LO, WAIT_NONE, JMP_NEVER, ADDR_IDLE);
            ADDR_MUL_HI:    w = uword(UOP_MUL_HI, WAIT_NONE, JMP_NEVER, ADDR_IDLE);
            ADDR_COMPARE:   w = uword(UOP_COMPARE, WAIT_NONE, JMP_NEVER, ADDR_IDLE);
            ADDR_DECIDE:    w = uword(UOP_DECIDE, WAIT_NONE, JMP_NO_AVG, ADDR_EMIT);
            ADDR_MUL_AVG:   w = uword(UOP_MUL_AVG, WAIT_NONE, JMP_NEVER, ADDR_IDLE);
            ADDR_SUM_AVG:   w = uword(UOP_SUM_AVG, WAIT_NONE, JMP_NEVER, ADDR_IDLE);
            [ADDR_DIV_FIRST:ADDR_DIV_LAST]:
                            w = uword(UOP_DIV_STEP, WAIT_NONE, JMP_NEVER, ADDR_IDLE);
            ADDR_AVG_DONE:  w = uword(UOP_AVG_DONE, WAIT_NONE, JMP_NEVER, ADDR_IDLE);
            ADDR_EMIT:      w = uword(UOP_EMIT, WAIT_OUTPUT, JMP_ALWAYS, ADDR_IDLE);
            default:        w = uword(UOP_NOP, WAIT_NONE, JMP_ALWAYS, ADDR_IDLE);
        endcase
        return w;
    endfunction

endpackage

/* design/pdcr_useq.sv */
// microprogram sequencer: step counter, control store and jump logic
module pdcr_useq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic                  out_busy,
    input  pdcr_pkg::pdcr_flags_t flags,
    output pdcr_pkg::pdcr_ctrl_t  ctrl
);

    logic [pdcr_pkg::UPC_W-1:0] upc_reg;
    logic [pdcr_pkg::UPC_W-1:0] upc_next;
    pdcr_pkg::pdcr_uword_t      word;
    logic                       hold;
    logic                       jump;

    assign word = pdcr_pkg::ucode_rom(upc_reg);

    always_comb begin
        unique case (word.wait_sel)
            pdcr_pkg::WAIT_INPUT:  hold = !in_valid;
            pdcr_pkg::WAIT_OUTPUT: hold = out_busy;
            default:               hold = 1'b0;
        endcase
    end

    always_comb begin
        unique case (word.jmp_sel)
            pdcr_pkg::JMP_ALWAYS: jump = 1'b1;
            pdcr_pkg::JMP_ACTION: jump = flags.action;
            pdcr_pkg::JMP_NO_AVG: jump = !flags.avg_needed;
            default:              jump = 1'b0;
        endcase
    end

    always_comb begin
        if (hold) begin
            upc_next = upc_reg;
        end else if (jump) begin
            upc_next = word.target;
        end else begin
            upc_next = upc_reg + {{(pdcr_pkg::UPC_W-1){1'b0}}, 1'b1};
        end
    end

    assign ctrl.uop  = hold ? pdcr_pkg::UOP_NOP : word.uop;
    assign ctrl.idle = (upc_reg == pdcr_pkg::ADDR_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= pdcr_pkg::ADDR_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

/* design/pdcr_dpath.sv */
// decoder datapath: accumulator, period, tolerance multiplier, divider and bit queue
module pdcr_dpath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pdcr_pkg::pdcr_ctrl_t  ctrl,
    input  pdcr_pkg::pdcr_in_t    in_data,
    input  logic [7:0]            tolerance,
    output pdcr_pkg::pdcr_flags_t flags,
    output logic                  emit,
    output pdcr_pkg::pdcr_out_t   result
);

    // control state
    logic [pdcr_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [pdcr_pkg::ACC_W-1:0] period_reg, period_next;
    logic                       last_level_reg, last_level_next;
    logic [2:0]                 sync_reg, sync_next;
    logic [7:0]                 queue_reg, queue_next;
    logic [2:0]                 fill_reg, fill_next;
    logic                       clock_reg, clock_next;
    logic                       produce_reg, produce_next;

    // working registers
    pdcr_pkg::pdcr_in_t          in_reg, in_next;
    logic [pdcr_pkg::PROD_W-1:0] lo_reg, lo_next;
    logic [pdcr_pkg::PROD_W-1:0] hi_reg, hi_next;
    logic                        intol_reg, intol_next;
    logic                        gt_reg, gt_next;
    logic [2:0]                  d_reg, d_next;
    logic [2:0]                  dm1_reg, dm1_next;
    logic [pdcr_pkg::DIV_W-1:0]  div_reg, div_next;
    logic [2:0]                  rem_reg, rem_next;

    logic [8:0]                  mul_b;
    logic [pdcr_pkg::PROD_W-1:0] mul_p;
    logic [pdcr_pkg::ACC_W:0]    acc_sum;
    logic [pdcr_pkg::PROD_W-1:0] acc_scaled;
    logic [7:0]                  queue_ins;
    logic [2:0]                  fill_ins;
    logic                        trans;
    logic [2:0]                  sync_dec;
    logic                        avg_needed;
    logic [pdcr_pkg::DIV_W-1:0]  div_step;
    logic [2:0]                  rem_step;

    // shared multiplier, operand picked by the micro-op
    always_comb begin
        case (ctrl.uop)
            pdcr_pkg::UOP_MUL_LO: mul_b = 9'd256 - {1'b0, tolerance};
            pdcr_pkg::UOP_MUL_HI: mul_b = 9'd256 + {1'b0, tolerance};
            default:              mul_b = {6'd0, dm1_reg};
        endcase
    end

    assign mul_p      = {9'd0, period_reg} * {24'd0, mul_b};
    assign acc_sum    = {1'b0, acc_reg} + {9'd0, in_reg.elapsed};
    assign acc_scaled = {1'b0, acc_reg, 8'd0};

    // queue insert of the current level at the fill position
    always_comb begin
        queue_ins           = queue_reg;
        queue_ins[fill_reg] = in_reg.level;
        fill_ins            = (fill_reg <= pdcr_pkg::DELAY_DEPTH) ? fill_reg + 3'd1 : fill_reg;
    end

    assign trans      = (in_reg.level != last_level_reg);
    assign sync_dec   = sync_reg - 3'd1;
    assign avg_needed = trans && (sync_reg != 3'd0)
                        && (sync_dec != pdcr_pkg::SYNC_BITS - 3'd1)
                        && !((period_reg != '0) && !intol_reg);

    // four restoring quotient bits per step, divisor is at most six
    always_comb begin
        logic [3:0]                 r4;
        logic [pdcr_pkg::DIV_W-1:0] q;
        logic [2:0]                 r;
        q = div_reg;
        r = rem_reg;
        for (int i = 0; i < 4; i++) begin
            r4 = {r, q[pdcr_pkg::DIV_W-1]};
            q  = {q[pdcr_pkg::DIV_W-2:0], 1'b0};
            if (r4 >= {1'b0, d_reg}) begin
                r4   = r4 - {1'b0, d_reg};
                q[0] = 1'b1;
            end
            r = r4[2:0];
        end
        div_step = q;
        rem_step = r;
    end

    always_comb begin
        acc_next        = acc_reg;
        period_next     = period_reg;
        last_level_next = last_level_reg;
        sync_next       = sync_reg;
        queue_next      = queue_reg;
        fill_next       = fill_reg;
        clock_next      = clock_reg;
        produce_next    = produce_reg;
        in_next         = in_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        intol_next      = intol_reg;
        gt_next         = gt_reg;
        d_next          = d_reg;
        dm1_next        = dm1_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;

        unique case (ctrl.uop)
            pdcr_pkg::UOP_LOAD: begin
                in_next = in_data;
            end
            pdcr_pkg::UOP_ACCUM: begin
                produce_next = 1'b0;
                if (in_reg.action) begin
                    last_level_next = 1'b0;
                    acc_next        = '0;
                    period_next     = '0;
                    sync_next       = pdcr_pkg::SYNC_BITS;
                end else if (acc_sum[pdcr_pkg::ACC_W]) begin
                    acc_next = '1;
                end else begin
                    acc_next = acc_sum[pdcr_pkg::ACC_W-1:0];
                end
            end
            pdcr_pkg::UOP_MUL_LO: begin
                lo_next = mul_p;
            end
            pdcr_pkg::UOP_MUL_HI: begin
                hi_next = mul_p;
            end
            pdcr_pkg::UOP_COMPARE: begin
                intol_next = (lo_reg < acc_scaled) && (acc_scaled < hi_reg);
                gt_next    = (acc_reg > period_reg);
            end
            pdcr_pkg::UOP_DECIDE: begin
                if (!trans) begin
                    if ((sync_reg == 3'd0) && gt_reg && !intol_reg) begin
                        last_level_next = 1'b0;
                        acc_next        = '0;
                        period_next     = '0;
                        sync_next       = pdcr_pkg::SYNC_BITS;
                        produce_next    = 1'b1;
                    end
                end else if (sync_reg != 3'd0) begin
                    last_level_next = in_reg.level;
                    sync_next       = sync_dec;
                    if (sync_dec == pdcr_pkg::SYNC_BITS - 3'd1) begin
                        // first sync edge: a rising edge starts the queue
                        if (in_reg.level) begin
                            queue_next = queue_ins;
                            fill_next  = fill_ins;
                            acc_next   = '0;
                        end
                    end else if ((period_reg != '0) && !intol_reg) begin
                        last_level_next = 1'b0;
                        acc_next        = '0;
                        period_next     = '0;
                        sync_next       = pdcr_pkg::SYNC_BITS;
                    end else begin
                        d_next   = pdcr_pkg::SYNC_BITS - sync_dec - 3'd1;
                        dm1_next = pdcr_pkg::SYNC_BITS - sync_dec - 3'd2;
                    end
                end else begin
                    last_level_next = in_reg.level;
                    if (intol_reg) begin
                        queue_next   = queue_ins;
                        fill_next    = fill_ins;
                        acc_next     = '0;
                        produce_next = 1'b1;
                    end else if (gt_reg) begin
                        last_level_next = 1'b0;
                        acc_next        = '0;
                        period_next     = '0;
                        sync_next       = pdcr_pkg::SYNC_BITS;
                    end
                end
            end
            pdcr_pkg::UOP_MUL_AVG: begin
                lo_next = mul_p;
            end
            pdcr_pkg::UOP_SUM_AVG: begin
                div_next = {1'b0, lo_reg[pdcr_pkg::DIV_W-2:0]} + {4'd0, acc_reg};
                rem_next = 3'd0;
            end
            pdcr_pkg::UOP_DIV_STEP: begin
                div_next = div_step;
                rem_next = rem_step;
            end
            pdcr_pkg::UOP_AVG_DONE: begin
                period_next  = div_reg[pdcr_pkg::ACC_W-1:0];
                queue_next   = queue_ins;
                fill_next    = fill_ins;
                acc_next     = '0;
                produce_next = 1'b1;
            end
            pdcr_pkg::UOP_EMIT: begin
                if (produce_reg) begin
                    clock_next = !clock_reg;
                    if (fill_reg != 3'd0) begin
                        fill_next  = fill_reg - 3'd1;
                        queue_next = {1'b0, queue_reg[7:1]};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign flags.action     = in_reg.action;
    assign flags.avg_needed = avg_needed;

    assign emit              = (ctrl.uop == pdcr_pkg::UOP_EMIT);
    assign result.bit_valid  = produce_reg;
    assign result.data_bit   = produce_reg && (fill_reg != 3'd0) && queue_reg[0];
    assign result.clock_line = clock_reg ^ produce_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg        <= '0;
            period_reg     <= '0;
            last_level_reg <= 1'b0;
            sync_reg       <= pdcr_pkg::SYNC_BITS;
            queue_reg      <= '0;
            fill_reg       <= '0;
            clock_reg      <= 1'b0;
            produce_reg    <= 1'b0;
        end else begin
            acc_reg        <= acc_next;
            period_reg     <= period_next;
            last_level_reg <= last_level_next;
            sync_reg       <= sync_next;
            queue_reg      <= queue_next;
            fill_reg       <= fill_next;
            clock_reg      <= clock_next;
            produce_reg    <= produce_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg    <= in_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        intol_reg <= intol_next;
        gt_reg    <= gt_next;
        d_reg     <= d_next;
        dm1_reg   <= dm1_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= pdcr_pkg::QUEUE_FULL)
        else $error("queue fill beyond delay depth");

    a_sync_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sync_reg <= pdcr_pkg::SYNC_BITS)
        else $error("sync count out of range");

    a_period_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (sync_reg == pdcr_pkg::SYNC_BITS) |-> (period_reg == '0))
        else $error("period kept across decoder restart");

endmodule

/* design/phase_decoder_clock_recovery.sv */
// top level of the phase decoder with clock recovery
// Each transaction on the s_ channel carries one thresholded tape level and
// the ticks since the previous sample, or a restart command (action = 1).
// Every input transaction yields exactly one m_ transaction: bit_valid tells
// whether a decoded bit came out, data_bit is the oldest bit of the delay
// queue, clock_line is the read clock that toggles on each produced bit.
// Control runs from a small microprogram: a restart goes from the accumulate
// step straight to emit, a plain sample also runs the two tolerance products,
// compare and decide, and a sync transition that updates the averaged bit
// period goes on through the averaging product on the shared multiplier, the
// sum, a divider that retires four quotient bits per cycle and the period
// update; the result is registered as the program returns to idle from emit.
// The next sample is accepted once the program is back at its idle step,
// even while the last result still waits in the output register.
// The tolerance register sits at byte address 0 of the APB-style port.
module phase_decoder_clock_recovery (
    input  logic                aclk,
    input  logic                aresetn,
    // sample input
    input  logic                s_valid,
    output logic                s_ready,
    input  pdcr_pkg::pdcr_in_t  s_data,
    // decoded output
    output logic                m_valid,
    input  logic                m_ready,
    output pdcr_pkg::pdcr_out_t m_data,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // register index decoded from paddr[2]
    localparam logic REG_TOLERANCE = 1'b0;

    logic [7:0]            tol_reg, tol_next;
    logic                  m_valid_reg, m_valid_next;
    pdcr_pkg::pdcr_out_t   m_data_reg, m_data_next;

    pdcr_pkg::pdcr_ctrl_t  ctrl;
    pdcr_pkg::pdcr_flags_t flags;
    pdcr_pkg::pdcr_out_t   result;
    logic                  emit;
    logic                  out_busy;
    logic                  cfg_write;

    // config port: pready is tied high
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TOLERANCE);
    assign tol_next  = cfg_write ? pwdata[7:0] : tol_reg;
    assign prdata    = (paddr[2] == REG_TOLERANCE) ? {24'd0, tol_reg} : 32'd0;

    // output register stalls the program at its emit step only
    assign out_busy = m_valid_reg && !m_ready;

    pdcr_useq u_useq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .out_busy (out_busy),
        .flags    (flags),
        .ctrl     (ctrl)
    );

    pdcr_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .in_data   (s_data),
        .tolerance (tol_reg),
        .flags     (flags),
        .emit      (emit),
        .result    (result)
    );

    // accept new samples whenever the program sits at its idle step
    assign s_ready = ctrl.idle;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg     <= pdcr_pkg::TOL_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            tol_reg     <= tol_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> !out_busy)
        else $error("result written over a pending transaction");

    a_idle_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.bit_valid) |-> !m_data.data_bit)
        else $error("data bit set without a produced bit");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("pending result dropped or changed");

endmodule
